// ===== rtl/spi_mse_pkg.sv =====
package spi_mse_pkg;

  // Transfer phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ADDR   = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_FINISH = 4'b1000
  } phase_t;

  // Item actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Transfer kinds
  localparam logic [1:0] KIND_BYTE_READ  = 2'd0;
  localparam logic [1:0] KIND_BYTE_WRITE = 2'd1;
  localparam logic [1:0] KIND_WORD_READ  = 2'd2;
  localparam logic [1:0] KIND_WORD_WRITE = 2'd3;

  // Last bit index of a byte and of a word
  localparam logic [3:0] LAST_BIT_BYTE = 4'd7;
  localparam logic [3:0] LAST_BIT_WORD = 4'd15;

  // Length reported for word transfers
  localparam logic [3:0] WORD_LENGTH = 4'd2;

  typedef struct packed {
    logic        action;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [2:0]  address_bytes;
    logic [63:0] write_data;
    logic [3:0]  data_count;
    logic        miso_level;
  } item_t;

  typedef struct packed {
    logic        sck_level;
    logic        cs_level;
    logic        mosi_level;
    logic        busy;
    logic        read_valid;
    logic [15:0] read_value;
    logic        read_last;
    logic        done;
    logic [3:0]  transfer_length;
  } res_t;

endpackage

// ===== rtl/spi_mse_core.sv =====
module spi_mse_core #(
  parameter int MAX_ADDR_BYTES = 4,
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  spi_mse_pkg::item_t  item,
  output spi_mse_pkg::res_t   res
);

  localparam logic [3:0] ADDR_LIMIT = 4'(MAX_ADDR_BYTES);
  localparam logic [3:0] DATA_LIMIT = 4'(MAX_DATA_BYTES);

  spi_mse_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [3:0]  bit_index_r, bit_index_nxt;
  logic [3:0]  byte_index_r, byte_index_nxt;
  logic        half_flag_r, half_flag_nxt;
  logic [31:0] addr_shift_r, addr_shift_nxt;
  logic [63:0] data_shift_r, data_shift_nxt;
  logic [15:0] rx_accum_r, rx_accum_nxt;
  logic [3:0]  addr_units_r, addr_units_nxt;
  logic [3:0]  data_units_r, data_units_nxt;
  logic        pin_sck_r, pin_sck_nxt;
  logic        pin_cs_r, pin_cs_nxt;
  logic        pin_mosi_r, pin_mosi_nxt;

  logic [3:0]  last_idx;
  logic [3:0]  units_sel;
  logic [3:0]  unit_off;
  logic [6:0]  tx_pos;
  logic        tx_bit;
  logic        sending;
  logic        sample;
  logic [15:0] rx_new;
  logic [3:0]  byte_inc;
  logic [3:0]  abytes_ext;
  logic [3:0]  a_sat;
  logic [3:0]  d_sat;

  // Bit position of the outgoing bit within the address or data word
  always_comb begin
    last_idx  = mode_r[1] ? spi_mse_pkg::LAST_BIT_WORD : spi_mse_pkg::LAST_BIT_BYTE;
    units_sel = (phase_r == spi_mse_pkg::PH_ADDR) ? addr_units_r : data_units_r;
    unit_off  = units_sel - 4'd1 - byte_index_r;
    if (mode_r[1]) begin
      tx_pos = {3'b000, spi_mse_pkg::LAST_BIT_WORD - bit_index_r};
    end else begin
      tx_pos = {unit_off, 3'b000} + {3'b000, spi_mse_pkg::LAST_BIT_BYTE - bit_index_r};
    end
    if (phase_r == spi_mse_pkg::PH_ADDR) begin
      tx_bit = (tx_pos < 7'd32) ? addr_shift_r[tx_pos[4:0]] : 1'b0;
    end else begin
      tx_bit = (tx_pos < 7'd64) ? data_shift_r[tx_pos[5:0]] : 1'b0;
    end
    sending  = (phase_r == spi_mse_pkg::PH_ADDR) || mode_r[0];
    rx_new   = {((bit_index_r == 4'd0) ? 15'd0 : rx_accum_r[14:0]), item.miso_level};
    byte_inc = byte_index_r + 4'd1;
    abytes_ext = {1'b0, item.address_bytes};
    a_sat    = (abytes_ext > ADDR_LIMIT) ? ADDR_LIMIT : abytes_ext;
    d_sat    = (item.data_count > DATA_LIMIT) ? DATA_LIMIT : item.data_count;
  end

  // Next state and result for one item
  always_comb begin
    phase_nxt      = phase_r;
    mode_nxt       = mode_r;
    bit_index_nxt  = bit_index_r;
    byte_index_nxt = byte_index_r;
    half_flag_nxt  = half_flag_r;
    addr_shift_nxt = addr_shift_r;
    data_shift_nxt = data_shift_r;
    rx_accum_nxt   = rx_accum_r;
    addr_units_nxt = addr_units_r;
    data_units_nxt = data_units_r;
    pin_sck_nxt    = pin_sck_r;
    pin_cs_nxt     = pin_cs_r;
    pin_mosi_nxt   = pin_mosi_r;
    sample         = 1'b0;
    res            = '0;

    if (item.action == spi_mse_pkg::ACT_LOAD) begin
      // Start a transfer; ignored while one is in progress
      if (phase_r == spi_mse_pkg::PH_IDLE) begin
        mode_nxt       = item.kind;
        addr_shift_nxt = item.address;
        data_shift_nxt = item.write_data;
        if (item.kind[1]) begin
          addr_units_nxt = 4'd1;
          data_units_nxt = 4'd1;
        end else begin
          addr_units_nxt = a_sat;
          data_units_nxt = d_sat;
        end
        bit_index_nxt  = 4'd0;
        byte_index_nxt = 4'd0;
        half_flag_nxt  = 1'b0;
        rx_accum_nxt   = 16'd0;
        if (addr_units_nxt != 4'd0) begin
          phase_nxt = spi_mse_pkg::PH_ADDR;
        end else if (data_units_nxt != 4'd0) begin
          phase_nxt = spi_mse_pkg::PH_DATA;
        end else begin
          phase_nxt = spi_mse_pkg::PH_FINISH;
        end
        pin_cs_nxt  = 1'b0;
        pin_sck_nxt = (item.kind == spi_mse_pkg::KIND_BYTE_READ);
      end
    end else if (phase_r == spi_mse_pkg::PH_FINISH) begin
      // Closing tick: deselect and park the clock high
      pin_cs_nxt  = 1'b1;
      pin_sck_nxt = 1'b1;
      phase_nxt   = spi_mse_pkg::PH_IDLE;
      res.done    = 1'b1;
      res.transfer_length = mode_r[1] ? spi_mse_pkg::WORD_LENGTH : data_units_r;
    end else if (phase_r != spi_mse_pkg::PH_IDLE) begin
      // Clock half-period
      if (!half_flag_r) begin
        if (sending) begin
          pin_mosi_nxt = tx_bit;
        end else if (mode_r == spi_mse_pkg::KIND_WORD_READ) begin
          pin_mosi_nxt = 1'b0;
        end
        if (mode_r == spi_mse_pkg::KIND_BYTE_READ) begin
          pin_sck_nxt = 1'b0;
        end else begin
          pin_sck_nxt = 1'b1;
          sample      = !sending;
        end
        half_flag_nxt = 1'b1;
      end else begin
        if (mode_r == spi_mse_pkg::KIND_BYTE_READ) begin
          pin_sck_nxt = 1'b1;
          sample      = !sending;
        end else begin
          pin_sck_nxt = 1'b0;
        end
        half_flag_nxt = 1'b0;
      end

      // Receive shift
      if (sample) begin
        rx_accum_nxt = rx_new;
        if (bit_index_r == last_idx) begin
          res.read_valid = 1'b1;
          res.read_value = rx_new;
          res.read_last  = (byte_index_r == data_units_r - 4'd1);
        end
      end

      // Bit and byte counters advance at the end of each bit
      if (half_flag_r) begin
        if (bit_index_r == last_idx) begin
          bit_index_nxt = 4'd0;
          if (phase_r == spi_mse_pkg::PH_ADDR && byte_inc >= addr_units_r) begin
            byte_index_nxt = 4'd0;
            if (data_units_r != 4'd0) begin
              phase_nxt = spi_mse_pkg::PH_DATA;
            end else begin
              phase_nxt = spi_mse_pkg::PH_FINISH;
            end
          end else if (phase_r == spi_mse_pkg::PH_DATA && byte_inc >= data_units_r) begin
            byte_index_nxt = 4'd0;
            phase_nxt      = spi_mse_pkg::PH_FINISH;
          end else begin
            byte_index_nxt = byte_inc;
          end
        end else begin
          bit_index_nxt = bit_index_r + 4'd1;
        end
      end
    end

    res.sck_level  = pin_sck_nxt;
    res.cs_level   = pin_cs_nxt;
    res.mosi_level = pin_mosi_nxt;
    res.busy       = (phase_nxt != spi_mse_pkg::PH_IDLE);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= spi_mse_pkg::PH_IDLE;
      mode_r       <= 2'd0;
      bit_index_r  <= 4'd0;
      byte_index_r <= 4'd0;
      half_flag_r  <= 1'b0;
      addr_shift_r <= 32'd0;
      data_shift_r <= 64'd0;
      rx_accum_r   <= 16'd0;
      addr_units_r <= 4'd0;
      data_units_r <= 4'd0;
      pin_sck_r    <= 1'b1;
      pin_cs_r     <= 1'b1;
      pin_mosi_r   <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      mode_r       <= mode_nxt;
      bit_index_r  <= bit_index_nxt;
      byte_index_r <= byte_index_nxt;
      half_flag_r  <= half_flag_nxt;
      addr_shift_r <= addr_shift_nxt;
      data_shift_r <= data_shift_nxt;
      rx_accum_r   <= rx_accum_nxt;
      addr_units_r <= addr_units_nxt;
      data_units_r <= data_units_nxt;
      pin_sck_r    <= pin_sck_nxt;
      pin_cs_r     <= pin_cs_nxt;
      pin_mosi_r   <= pin_mosi_nxt;
    end
  end

  // Chip select is high exactly when no transfer is open
  a_cs_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == spi_mse_pkg::PH_IDLE) |-> pin_cs_r)
    else $error("chip select low while idle");

  a_cs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != spi_mse_pkg::PH_IDLE) |-> !pin_cs_r)
    else $error("chip select high during transfer");

  // Mid-bit only inside a shifting phase
  a_half_phase: assert property (@(posedge clk) disable iff (!rst_n)
    half_flag_r |-> (phase_r == spi_mse_pkg::PH_ADDR || phase_r == spi_mse_pkg::PH_DATA))
    else $error("half period outside shift phase");

  // Byte modes never count past bit seven
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    !mode_r[1] |-> (bit_index_r <= spi_mse_pkg::LAST_BIT_BYTE))
    else $error("bit index out of byte range");

  // Closing tick always leaves the pins deselected with the clock high
  a_done_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.done) |=> (pin_cs_r && pin_sck_r && phase_r == spi_mse_pkg::PH_IDLE))
    else $error("transfer end left pins wrong");

endmodule

// ===== rtl/spi_master_shift_engine_unit.sv =====
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall  | action, kind, address, address_bytes,
//         |           |                      | write_data, data_count, miso_level
// out_    | output    | out_valid / out_stall| pin levels, busy, read value/flags,
//         |           |                      | done, transfer_length
//
// One transaction in gives one transaction out, through the input and result registers.
// Throughput is one transaction per cycle when unstalled; the engine state updates in the cycle
// the input register hands its transaction to the result register.
// Synchronous active-low reset: pins idle with sck high, cs high, mosi low.
// A stall on out_ holds the result register and backs up into in_stall in the
// same cycle; a result waiting there does not keep in_ from filling its register.
module spi_master_shift_engine_unit #(
  parameter int MAX_ADDR_BYTES = 4,
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_address,
  input  logic [2:0]  in_address_bytes,
  input  logic [63:0] in_write_data,
  input  logic [3:0]  in_data_count,
  input  logic        in_miso_level,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_sck_level,
  output logic        out_cs_level,
  output logic        out_mosi_level,
  output logic        out_busy_res,
  output logic        out_read_valid,
  output logic [15:0] out_read_value,
  output logic        out_read_last,
  output logic        out_done_res,
  output logic [3:0]  out_transfer_length
);

  logic               in_valid_r;
  spi_mse_pkg::item_t in_item_r;
  logic               out_valid_r;
  spi_mse_pkg::res_t  out_res_r;
  spi_mse_pkg::res_t  step_res;
  logic               advance;
  logic               fire;

  // Result register frees up when empty or drained this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r.action        <= in_action;
      in_item_r.kind          <= in_kind;
      in_item_r.address       <= in_address;
      in_item_r.address_bytes <= in_address_bytes;
      in_item_r.write_data    <= in_write_data;
      in_item_r.data_count    <= in_data_count;
      in_item_r.miso_level    <= in_miso_level;
    end
  end

  // Engine state and step logic
  spi_mse_core #(
    .MAX_ADDR_BYTES (MAX_ADDR_BYTES),
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .res   (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sck_level       = out_res_r.sck_level;
  assign out_cs_level        = out_res_r.cs_level;
  assign out_mosi_level      = out_res_r.mosi_level;
  assign out_busy_res        = out_res_r.busy;
  assign out_read_valid      = out_res_r.read_valid;
  assign out_read_value      = out_res_r.read_value;
  assign out_read_last       = out_res_r.read_last;
  assign out_done_res        = out_res_r.done;
  assign out_transfer_length = out_res_r.transfer_length;

endmodule
